// ----- rtl/pid_backcalc_antiwindup_unit_defines.svh -----
// ----------------------------------------------------------------------------
// PID unit assertion macros
// Assertion helpers for the PID unit; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_BACKCALC_ANTIWINDUP_UNIT_DEFINES_SVH
`define PID_BACKCALC_ANTIWINDUP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PBAW_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("PID unit: same-cycle check failed");
`define PBAW_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("PID unit: next-cycle check failed");
`else
`define PBAW_ASSERT_IMPLY(name, clk, rst, pre, post)
`define PBAW_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

// ----- rtl/pbaw_pkg.sv -----
// ----------------------------------------------------------------------------
// PID unit package
// Types, codes, the microcode table and the saturation helper of the PID unit.
// ----------------------------------------------------------------------------
package pbaw_pkg;

   localparam int DIV_WIDTH  = 64;
   localparam int DIV_STEPS  = DIV_WIDTH / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int GAIN_WIDTH = 16;

   localparam logic [2:0] CSR_OUT_MIN = 3'd0;
   localparam logic [2:0] CSR_OUT_MAX = 3'd1;
   localparam logic [2:0] CSR_GAIN_P  = 3'd2;
   localparam logic [2:0] CSR_GAIN_I  = 3'd3;
   localparam logic [2:0] CSR_GAIN_D  = 3'd4;

   localparam logic [1:0] SAT_NONE = 2'd0;
   localparam logic [1:0] SAT_MAX  = 2'd1;
   localparam logic [1:0] SAT_MIN  = 2'd2;

   localparam logic [3:0] STEP_INTEG   = 4'd0;
   localparam logic [3:0] STEP_DIVWAIT = 4'd7;
   localparam logic [3:0] STEP_APPLY   = 4'd8;
   localparam logic [3:0] STEP_FINISH  = 4'd9;
   localparam logic [3:0] STEP_CLEAR   = 4'd10;

   localparam logic signed [47:0] INT48_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] INT48_MIN = {1'b1, {47{1'b0}}};

   typedef enum logic [2:0] {
      OP_NONE, OP_INTEG, OP_CLAMP, OP_APPLY, OP_FINISH, OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {GSEL_P, GSEL_I, GSEL_D} gain_sel_type;

   typedef enum logic [1:0] {BSEL_ERR, BSEL_DERIV, BSEL_ILO, BSEL_IHI} opb_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD, ACC_CLEAR, ACC_ADD0, ACC_ADD8, ACC_ADD24
   } acc_op_type;

   typedef enum logic [2:0] {
      SEQ_NEXT, SEQ_BRANCH, SEQ_WAIT_DIV, SEQ_WAIT_OUT, SEQ_END
   } seq_type;

   typedef struct packed {
      op_type       op;
      gain_sel_type gsel;
      opb_sel_type  bsel;
      acc_op_type   acc;
      seq_type      seq;
      logic [3:0]   target;
   } ctrl_word_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [14:0]          divisor;
   } div_req_type;

   function automatic ctrl_word_type ucode_rom(input logic [3:0] step);
      ctrl_word_type cw;
      cw = '{op: OP_NONE, gsel: GSEL_P, bsel: BSEL_ERR, acc: ACC_HOLD,
             seq: SEQ_NEXT, target: STEP_INTEG};
      unique case (step)
         4'd0: cw.op = OP_INTEG;
         4'd1: begin
            cw.gsel = GSEL_P;
            cw.bsel = BSEL_ERR;
            cw.acc  = ACC_CLEAR;
         end
         4'd2: begin
            cw.gsel = GSEL_D;
            cw.bsel = BSEL_DERIV;
            cw.acc  = ACC_ADD8;
         end
         4'd3: begin
            cw.gsel = GSEL_I;
            cw.bsel = BSEL_ILO;
            cw.acc  = ACC_ADD8;
         end
         4'd4: begin
            cw.gsel = GSEL_I;
            cw.bsel = BSEL_IHI;
            cw.acc  = ACC_ADD0;
         end
         4'd5: cw.acc = ACC_ADD24;
         4'd6: begin
            cw.op     = OP_CLAMP;
            cw.seq    = SEQ_BRANCH;
            cw.target = STEP_FINISH;
         end
         4'd7: cw.seq = SEQ_WAIT_DIV;
         4'd8: cw.op = OP_APPLY;
         4'd9: begin
            cw.op  = OP_FINISH;
            cw.seq = SEQ_WAIT_OUT;
         end
         4'd10: begin
            cw.op  = OP_CLEAR;
            cw.seq = SEQ_END;
         end
         default: cw.seq = SEQ_END;
      endcase
      return cw;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
      logic signed [47:0] r;
      if (v > 66'(INT48_MAX)) begin
         r = INT48_MAX;
      end else if (v < 66'(INT48_MIN)) begin
         r = INT48_MIN;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/pbaw_div.sv -----
// ----------------------------------------------------------------------------
// PID unit serial divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pbaw_div (
   input  logic                              clock,
   input  logic                              reset,
   input  pbaw_pkg::div_req_type             req,
   output logic                              busy,
   output logic [pbaw_pkg::DIV_WIDTH-1:0]    quotient
);
   import pbaw_pkg::*;

   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_WIDTH-1:0]  num_ff, num_in;
   logic [14:0]           rem_ff, rem_in;
   logic [14:0]           div_ff, div_in;
   logic [15:0]           r_a, r_b;
   logic                  ge_a, ge_b;
   logic [14:0]           rem_a;

   always_comb begin
      r_a   = {rem_ff, num_ff[DIV_WIDTH-1]};
      ge_a  = r_a >= {1'b0, div_ff};
      rem_a = ge_a ? 15'(r_a - {1'b0, div_ff}) : r_a[14:0];
      r_b   = {rem_a, num_ff[DIV_WIDTH-2]};
      ge_b  = r_b >= {1'b0, div_ff};

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         num_in  = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_WIDTH-3:0], ge_a, ge_b};
         rem_in = ge_b ? 15'(r_b - {1'b0, div_ff}) : r_b[14:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

// ----- rtl/pid_backcalc_antiwindup_unit.sv -----
// ----------------------------------------------------------------------------
// PID controller with back-calculation anti-windup
// Microcoded fixed-point PID step with clamped output and integral correction.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Contents
// req       in         req_tvalid/req_tready    setpoint, measurement, command
// rsp       out        rsp_tvalid/rsp_tready    drive, saturation code
// csr       in         csr_we                   register writes, no read-back
//
// A compute item uses the serial divider (two bits a cycle over 64 bits)
// only when the output clamps with a positive integral gain. A clear item
// gives no result. One item is in work at a time; a result waits in the
// output register while the next item is taken, and a full output register
// holds the last step. Reset is synchronous and clears the state and the
// registers to their defaults.
// ----------------------------------------------------------------------------
`include "pid_backcalc_antiwindup_unit_defines.svh"

module pid_backcalc_antiwindup_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // target [15:0], measured [31:16]
   input  logic        req_tuser,   // command (0 compute, 1 clear)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // drive [15:0], saturated [17:16], zero [23:18]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import pbaw_pkg::*;

   logic signed [15:0] out_min_ff, out_min_in, out_max_ff, out_max_in;
   logic signed [15:0] gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   logic               busy_ff, busy_in;
   logic [3:0]         pc_ff, pc_in;
   logic signed [16:0] e_ff, e_in, last_err_ff, last_err_in;
   logic               tgt_zero_ff, tgt_zero_in;
   logic signed [17:0] d_ff, d_in;
   logic signed [47:0] integ_ff, integ_in;
   logic signed [41:0] prod_ff, prod_in;
   logic signed [65:0] acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic [15:0]        drive_ff, drive_in;
   logic [1:0]         sat_ff, sat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_drive_ff, rsp_drive_in;
   logic [1:0]         rsp_sat_ff, rsp_sat_in;

   ctrl_word_type      cw;
   logic               accept, can_emit, gt, lt, backcalc;
   logic signed [16:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [65:0] hi_lim, lo_lim, diff, mag, qs;
   logic [15:0]        trunc;
   div_req_type        div_req;
   logic               div_busy;
   logic [DIV_WIDTH-1:0] div_q;

   pbaw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign cw         = ucode_rom(pc_ff);
   assign can_emit   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      out_min_in = out_min_ff;
      out_max_in = out_max_ff;
      gain_p_in  = gain_p_ff;
      gain_i_in  = gain_i_ff;
      gain_d_in  = gain_d_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OUT_MIN: out_min_in = csr_wdata;
            CSR_OUT_MAX: out_max_in = csr_wdata;
            CSR_GAIN_P:  gain_p_in  = csr_wdata;
            CSR_GAIN_I:  gain_i_in  = csr_wdata;
            CSR_GAIN_D:  gain_d_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cw.gsel)
         GSEL_P:  mul_a = 17'(gain_p_ff);
         GSEL_I:  mul_a = 17'(gain_i_ff);
         GSEL_D:  mul_a = 17'(gain_d_ff);
         default: mul_a = 17'(gain_p_ff);
      endcase
      case (cw.bsel)
         BSEL_ERR:   mul_b = 25'(e_ff);
         BSEL_DERIV: mul_b = 25'(d_ff);
         BSEL_ILO:   mul_b = $signed({1'b0, integ_ff[23:0]});
         BSEL_IHI:   mul_b = 25'($signed(integ_ff[47:24]));
         default:    mul_b = 25'(e_ff);
      endcase
      prod_in = 42'(mul_a) * 42'(mul_b);
   end

   always_comb begin
      hi_lim   = 66'(out_max_ff) <<< 16;
      lo_lim   = 66'(out_min_ff) <<< 16;
      gt       = acc_ff > hi_lim;
      lt       = acc_ff < lo_lim;
      backcalc = (gt || lt) && (gain_i_ff > 16'sd0);
      diff     = acc_ff - (gt ? hi_lim : lo_lim);
      mag      = diff[65] ? -diff : diff;
      trunc    = acc_ff[31:16] + 16'(acc_ff[65] && (acc_ff[15:0] != 16'd0));
      qs       = neg_ff ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

      div_req.start    = busy_ff && (cw.op == OP_CLAMP) && backcalc;
      div_req.dividend = mag[DIV_WIDTH-1:0];
      div_req.divisor  = gain_i_ff[14:0];
   end

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      e_in         = e_ff;
      tgt_zero_in  = tgt_zero_ff;
      d_in         = d_ff;
      last_err_in  = last_err_ff;
      integ_in     = integ_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      drive_in     = drive_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_drive_in = rsp_drive_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (accept) begin
         busy_in     = 1'b1;
         pc_in       = req_tuser ? STEP_CLEAR : STEP_INTEG;
         e_in        = 17'($signed(req_tdata[15:0])) - 17'($signed(req_tdata[31:16]));
         tgt_zero_in = (req_tdata[15:0] == 16'd0) && (req_tdata[31:16] == 16'd0);
      end else if (busy_ff) begin
         case (cw.acc)
            ACC_CLEAR: acc_in = '0;
            ACC_ADD0:  acc_in = acc_ff + 66'(prod_ff);
            ACC_ADD8:  acc_in = acc_ff + (66'(prod_ff) <<< 8);
            ACC_ADD24: acc_in = acc_ff + (66'(prod_ff) <<< 24);
            default:   acc_in = acc_ff;
         endcase

         case (cw.op)
            OP_INTEG: begin
               d_in     = 18'(e_ff) - 18'(last_err_ff);
               integ_in = sat48(66'(integ_ff) + (66'(e_ff) <<< 8));
            end
            OP_CLAMP: begin
               neg_in = diff[65];
               if (gt) begin
                  drive_in = out_max_ff;
                  sat_in   = SAT_MAX;
               end else if (lt) begin
                  drive_in = out_min_ff;
                  sat_in   = SAT_MIN;
               end else begin
                  drive_in = trunc;
                  sat_in   = SAT_NONE;
               end
            end
            OP_APPLY: integ_in = sat48(66'(integ_ff) - qs);
            OP_FINISH: begin
               if (can_emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_drive_in = drive_ff;
                  rsp_sat_in   = sat_ff;
                  last_err_in  = e_ff;
                  if (tgt_zero_ff) begin
                     integ_in = '0;
                     d_in     = '0;
                  end
               end
            end
            OP_CLEAR: begin
               integ_in    = '0;
               last_err_in = '0;
               d_in        = '0;
            end
            default: ;
         endcase

         case (cw.seq)
            SEQ_NEXT:     pc_in = pc_ff + 1'b1;
            SEQ_BRANCH:   pc_in = backcalc ? pc_ff + 1'b1 : cw.target;
            SEQ_WAIT_DIV: pc_in = div_busy ? pc_ff : pc_ff + 1'b1;
            SEQ_WAIT_OUT: busy_in = !can_emit;
            default:      busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_min_ff   <= 16'sh8000;
         out_max_ff   <= 16'sh7FFF;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         busy_ff      <= 1'b0;
         pc_ff        <= STEP_INTEG;
         last_err_ff  <= '0;
         integ_ff     <= '0;
         d_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         out_min_ff   <= out_min_in;
         out_max_ff   <= out_max_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
         d_ff         <= d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff         <= e_in;
      tgt_zero_ff  <= tgt_zero_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      drive_ff     <= drive_in;
      sat_ff       <= sat_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_sat_ff, rsp_drive_ff};

   // The divider runs only while the sequencer waits for it.
   `PBAW_ASSERT_IMPLY(a_div_in_wait, clock, reset, div_busy, busy_ff && (pc_ff == STEP_DIVWAIT))
   // The integral correction only follows a clamped output.
   `PBAW_ASSERT_IMPLY(a_apply_clamped, clock, reset, busy_ff && (pc_ff == STEP_APPLY), sat_ff != SAT_NONE)
   // A clear item produces no result.
   `PBAW_ASSERT_NEXT(a_clear_silent, clock, reset, accept && req_tuser && !rsp_valid_ff, !rsp_valid_ff)

endmodule

// ----- verif/pid_backcalc_antiwindup_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID unit testbench
// Drives compute and clear items through the PID unit under a series of limit
// and gain settings. Each accepted item updates a local integral and error
// model that predicts drive and saturation code, and each returned item is
// compared with the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module pid_backcalc_antiwindup_unit_tb;
   import pbaw_pkg::*;

   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;
   localparam int SETTLE_CYCLES = 60;
   localparam int QUIET_LIMIT   = 4000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 95;

   typedef struct {
      logic              clear;
      logic signed [15:0] target;
      logic signed [15:0] measured;
   } pid_step_type;

   typedef struct {
      logic signed [15:0] drive;
      logic [1:0]         saturated;
   } pid_drive_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   logic signed [15:0] lim_min = -16'sd32768;
   logic signed [15:0] lim_max = 16'sd32767;
   logic signed [15:0] k_p = '0;
   logic signed [15:0] k_i = '0;
   logic signed [15:0] k_d = '0;
   longint integ_sum = 0;
   longint prev_error = 0;
   longint prev_deriv = 0;

   logic signed [15:0] corner [5] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};

   pid_step_type  pending[$];
   pid_drive_type drive_expected[$];
   pid_step_type  next_step;
   pid_step_type  seen_step;
   pid_drive_type want;
   int fail_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   pid_backcalc_antiwindup_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint clip48(input longint v);
      if (v > longint'(INT48_MAX)) return longint'(INT48_MAX);
      if (v < longint'(INT48_MIN)) return longint'(INT48_MIN);
      return v;
   endfunction

   function automatic void advance_pid(input pid_step_type it);
      longint e, s, hi, lo;
      pid_drive_type r;
      if (it.clear == CMD_CLEAR) begin
         integ_sum = 0;
         prev_error = 0;
         prev_deriv = 0;
      end else begin
         e = longint'(it.target) - longint'(it.measured);
         prev_deriv = e - prev_error;
         integ_sum = clip48(integ_sum + e * 256);
         s = longint'(k_p) * e * 256 + longint'(k_i) * integ_sum
             + longint'(k_d) * prev_deriv * 256;
         hi = longint'(lim_max) * 65536;
         lo = longint'(lim_min) * 65536;
         r.saturated = SAT_NONE;
         if (s > hi) begin
            if (k_i > 0) integ_sum = clip48(integ_sum - (s - hi) / longint'(k_i));
            r.drive = lim_max;
            r.saturated = SAT_MAX;
         end else if (s < lo) begin
            if (k_i > 0) integ_sum = clip48(integ_sum - (s - lo) / longint'(k_i));
            r.drive = lim_min;
            r.saturated = SAT_MIN;
         end else begin
            r.drive = 16'(s / 65536);
         end
         // A zero setpoint with the process at rest drops the accumulated terms.
         if (it.target == 0 && e == 0) begin
            integ_sum = 0;
            prev_deriv = 0;
         end
         prev_error = e;
         drive_expected.push_back(r);
      end
   endfunction

   function automatic pid_step_type make_step(input logic clear, input logic signed [15:0] t,
                                              input logic signed [15:0] m);
      pid_step_type it;
      it.clear = clear;
      it.target = t;
      it.measured = m;
      return it;
   endfunction

   function automatic logic signed [15:0] random_gain();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 600)) - 16'sd300;
         2: return corner[$urandom_range(0, 4)];
         default: return 16'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic pid_step_type random_step();
      pid_step_type it;
      it.clear = ($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_STEP;
      case ($urandom_range(0, 3))
         0: begin
            it.target = 16'($urandom);
            it.measured = 16'($urandom);
         end
         1: begin
            it.target = 16'($urandom);
            it.measured = it.target + 16'($urandom_range(0, 16)) - 16'sd8;
         end
         2: begin
            it.target = '0;
            it.measured = $urandom_range(0, 1) ? '0 : 16'($urandom_range(0, 16)) - 16'sd8;
         end
         default: begin
            it.target = corner[$urandom_range(0, 4)];
            it.measured = corner[$urandom_range(0, 4)];
         end
      endcase
      return it;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic signed [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_OUT_MIN: lim_min = val;
         CSR_OUT_MAX: lim_max = val;
         CSR_GAIN_P:  k_p = val;
         CSR_GAIN_I:  k_i = val;
         CSR_GAIN_D:  k_d = val;
         default: ;
      endcase
   endtask

   task automatic configure(input logic signed [15:0] mn, input logic signed [15:0] mx,
                            input logic signed [15:0] p, input logic signed [15:0] i,
                            input logic signed [15:0] d);
      write_reg(CSR_OUT_MIN, mn);
      write_reg(CSR_OUT_MAX, mx);
      write_reg(CSR_GAIN_P, p);
      write_reg(CSR_GAIN_I, i);
      write_reg(CSR_GAIN_D, d);
      // Indexes past the last register must leave every setting untouched.
      write_reg(3'(CSR_GAIN_D + 3'($urandom_range(1, 3))), 16'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_config();
      logic signed [15:0] a, b, t;
      a = 16'($urandom);
      b = 16'($urandom);
      if ($urandom_range(0, 3) != 0 && a > b) begin
         t = a;
         a = b;
         b = t;
      end
      configure(a, b, random_gain(), random_gain(), random_gain());
   endtask

   task automatic settle();
      while (pending.size() != 0 || req_tvalid || drive_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending.size() > 0) begin
            next_step = pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {next_step.measured, next_step.target};
            req_tuser <= next_step.clear;
            if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 7);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen_step.clear = req_tuser;
            seen_step.target = req_tdata[15:0];
            seen_step.measured = req_tdata[31:16];
            advance_pid(seen_step);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (drive_expected.size() == 0) begin
               $error("unexpected result item: drive %0d, saturated %0d",
                      $signed(rsp_tdata[15:0]), rsp_tdata[17:16]);
               fail_count++;
            end else begin
               want = drive_expected.pop_front();
               if ($signed(rsp_tdata[15:0]) != want.drive) begin
                  $error("drive: expected %0d, actual %0d", want.drive,
                         $signed(rsp_tdata[15:0]));
                  fail_count++;
               end
               if (rsp_tdata[17:16] != want.saturated) begin
                  $error("saturated: expected %0d, actual %0d", want.saturated,
                         rsp_tdata[17:16]);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int ph, n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // With the reset gains every step drives zero.
      pending.push_back(make_step(CMD_STEP, 16'sd1000, -16'sd1000));
      pending.push_back(make_step(CMD_STEP, 16'sd0, 16'sd0));
      pending.push_back(make_step(CMD_CLEAR, 16'sd5, 16'sd5));
      settle();

      configure(-16'sd100, 16'sd100, 16'sd256, 16'sd1, 16'sd128);
      pending.push_back(make_step(CMD_STEP, 16'sd0, 16'sd0));
      pending.push_back(make_step(CMD_STEP, 16'sd32767, -16'sd32768));
      pending.push_back(make_step(CMD_STEP, -16'sd32768, 16'sd32767));
      pending.push_back(make_step(CMD_STEP, 16'sd0, 16'sd0));
      pending.push_back(make_step(CMD_STEP, 16'sd0, 16'sd1));
      pending.push_back(make_step(CMD_STEP, -16'sd1, 16'sd0));
      pending.push_back(make_step(CMD_STEP, 16'sd32767, 16'sd32767));
      pending.push_back(make_step(CMD_STEP, -16'sd32768, -16'sd32768));
      pending.push_back(make_step(CMD_STEP, 16'sd0, -16'sd32768));
      pending.push_back(make_step(CMD_STEP, 16'sd0, 16'sd32767));
      pending.push_back(make_step(CMD_CLEAR, -16'sd1, 16'sd1));
      pending.push_back(make_step(CMD_STEP, 16'sd10, 16'sd0));
      pending.push_back(make_step(CMD_STEP, 16'sd10, 16'sd5));
      pending.push_back(make_step(CMD_STEP, 16'sd10, 16'sd10));
      pending.push_back(make_step(CMD_STEP, 16'sd0, 16'sd0));
      pending.push_back(make_step(CMD_STEP, -16'sd32768, 16'sd0));
      pending.push_back(make_step(CMD_STEP, 16'sd32767, 16'sd0));
      pending.push_back(make_step(CMD_STEP, 16'sd50, 16'sd49));
      settle();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: configure(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
            1: configure(-16'sd5, 16'sd5, -16'sd32768, -16'sd32768, -16'sd32768);
            2: configure(16'sd50, -16'sd50, 16'sd300, 16'sd300, -16'sd300);
            3: configure(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd1);
            4: configure(-16'sd32768, 16'sd32767, 16'sd2, 16'sd1, 16'sd0);
            default: random_config();
         endcase
         if (ph == RANDOM_PHASES - 1) calm = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) pending.push_back(random_step());
         settle();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pbaw_pkg.sv
rtl/pbaw_div.sv
rtl/pid_backcalc_antiwindup_unit.sv
verif/pid_backcalc_antiwindup_unit_tb.sv
